FILE: hdl/bdec_pkg.sv
// package for the binned decimator: widths, mode and register codes,
// controller states and the command / status structs
// no dependencies
`timescale 1ns / 1ps

package bdec_pkg;

    localparam int SAMPLE_BITS  = 32;
    localparam int LENGTH_BITS  = 24;
    // exact bin sum needs one sample width plus one count width
    localparam int SUM_BITS     = SAMPLE_BITS + LENGTH_BITS;
    // boundary accumulator holds input_length * output_size at most
    localparam int BOUND_BITS   = 2 * LENGTH_BITS;
    // boundary numerator 2 * bound + size
    localparam int NUM_BITS     = BOUND_BITS + 2;
    localparam int DIV_BITS     = (SUM_BITS > NUM_BITS) ? SUM_BITS : NUM_BITS;
    localparam int DEN_BITS     = LENGTH_BITS + 1;
    localparam int DIV_CNT_BITS = $clog2(DIV_BITS);
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LENGTH = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SIZE   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE   = 2'd2;

    typedef enum logic [1:0] {
        MODE_MAX  = 2'd0,
        MODE_MIN  = 2'd1,
        MODE_MAG  = 2'd2,
        MODE_MEAN = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_INIT,
        ST_END_DIV,
        ST_RUN,
        ST_FINISH,
        ST_MEAN_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic accept;
        logic start_end_div;
        logic start_mean_div;
        logic load_end;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic cfg_hit;
        logic at_end;
        logic div_done;
        logic out_free;
        logic mean_mode;
    } t_status;

endpackage

FILE: hdl/binned_decimator_int.sv
// top level of the binned decimator: joins controller and datapath
// depends on bdec_pkg, bdec_ctrl, bdec_dp (and bdec_div below it)
`timescale 1ns / 1ps
// usage
//   input channel: i_valid / o_stall / i_sample, one signed sample per transfer
//   output channel: o_valid / i_stall / o_bin_value, o_bin_number, o_last_bin,
//   one result per finished bin, held in an output register until taken
//   config port: i_cfg_we / i_cfg_idx / i_cfg_data; index 0 input_length,
//   1 output_size, 2 reduce_mode; any of these writes restarts the vector and
//   drops a partial bin, a write to index 3 is ignored
// timing
//   samples inside a bin transfer at one per cycle
//   the sample that closes a bin stalls the input while the bin boundary for the
//   next bin comes from a shared one-bit-per-cycle divider (56 steps)
//   in mean mode the bin mean runs through the same divider first
//   result is loaded into the output register from the EMIT state, after FINISH in
//   max / min / magnitude modes and after FINISH and the mean division in mean mode
// reset and stall
//   after reset, and after each register write, the input stalls while the
//   first bin boundary is computed
//   a result waiting behind i_stall does not block samples of the next bin;
//   once that bin closes, the input stays stalled until the output register frees

module binned_decimator_int
    import bdec_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [LENGTH_BITS-1:0]        i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_bin_value,
    output logic [LENGTH_BITS-1:0]        o_bin_number,
    output logic                          o_last_bin
);

    // command and status between controller and datapath
    t_cmd    cmd;
    t_status status;

    bdec_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    bdec_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_sample     (i_sample),
        .i_stall      (i_stall),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_valid      (o_valid),
        .o_bin_value  (o_bin_value),
        .o_bin_number (o_bin_number),
        .o_last_bin   (o_last_bin)
    );

endmodule

FILE: hdl/bdec_div.sv
// unsigned restoring divider, one quotient bit per cycle
// depends on bdec_pkg
`timescale 1ns / 1ps

module bdec_div
    import bdec_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DIV_BITS-1:0] i_dividend,
    input  logic [DEN_BITS-1:0] i_divisor,
    output logic                o_busy,
    output logic [DIV_BITS-1:0] o_quotient
);

    logic [DEN_BITS-1:0]     r_rem;
    logic [DIV_BITS-1:0]     r_quo;
    logic [DEN_BITS-1:0]     r_den;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic                    r_busy;

    logic [DEN_BITS:0] shifted;
    logic [DEN_BITS:0] diff;
    logic              fits;

    assign shifted = {r_rem, r_quo[DIV_BITS-1]};
    assign diff    = shifted - {1'b0, r_den};
    assign fits    = (shifted >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_BITS'(DIV_BITS - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
            r_quo <= {r_quo[DIV_BITS-2:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

FILE: hdl/bdec_dp.sv
// datapath: configuration registers, bin state, reductions, shared divider
// and output register; depends on bdec_pkg and bdec_div
`timescale 1ns / 1ps

module bdec_dp
    import bdec_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [LENGTH_BITS-1:0]        i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_stall,
    input  t_cmd                          i_cmd,
    output t_status                       o_status,
    output logic                          o_valid,
    output logic signed [SAMPLE_BITS-1:0] o_bin_value,
    output logic [LENGTH_BITS-1:0]        o_bin_number,
    output logic                          o_last_bin
);

    // configuration
    logic [LENGTH_BITS-1:0] r_len;
    logic [LENGTH_BITS-1:0] r_size;
    t_mode                  r_mode;

    // bin state
    logic [LENGTH_BITS-1:0]        r_seen, n_seen;
    logic [LENGTH_BITS-1:0]        r_bins, n_bins;
    logic [BOUND_BITS-1:0]         r_bound, n_bound;
    logic [LENGTH_BITS-1:0]        r_bin_end, n_bin_end;
    logic signed [SAMPLE_BITS-1:0] r_ext, n_ext;
    logic signed [SUM_BITS-1:0]    r_sum, n_sum;
    logic [LENGTH_BITS-1:0]        r_fill, n_fill;

    // output register
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_value;
    logic [LENGTH_BITS-1:0]        r_out_number;
    logic                          r_out_last;

    logic [LENGTH_BITS-1:0]    len_eff;
    logic [LENGTH_BITS-1:0]    size_nz;
    logic [LENGTH_BITS-1:0]    bins_eff;
    logic                      last;
    logic [SAMPLE_BITS:0]      x_ext;
    logic [SAMPLE_BITS:0]      ext_ext;
    logic [SAMPLE_BITS:0]      x_mag;
    logic [SAMPLE_BITS:0]      ext_mag;
    logic [SUM_BITS-1:0]       sum_mag;
    logic [SAMPLE_BITS-1:0]    quo_low;
    logic signed [SAMPLE_BITS-1:0] mean_val;
    logic                      div_start;
    logic [DIV_BITS-1:0]       div_dividend;
    logic [DEN_BITS-1:0]       div_divisor;
    logic                      div_busy;
    logic [DIV_BITS-1:0]       div_quo;

    assign len_eff  = (r_len == '0) ? LENGTH_BITS'(1) : r_len;
    assign size_nz  = (r_size == '0) ? LENGTH_BITS'(1) : r_size;
    assign bins_eff = (size_nz > len_eff) ? len_eff : size_nz;
    assign last     = (({1'b0, r_bins} + 1'b1) >= {1'b0, bins_eff});

    assign x_ext   = {i_sample[SAMPLE_BITS-1], i_sample};
    assign ext_ext = {r_ext[SAMPLE_BITS-1], r_ext};
    assign x_mag   = x_ext[SAMPLE_BITS] ? (~x_ext + 1'b1) : x_ext;
    assign ext_mag = ext_ext[SAMPLE_BITS] ? (~ext_ext + 1'b1) : ext_ext;
    assign sum_mag = r_sum[SUM_BITS-1] ? (~r_sum + 1'b1) : r_sum;

    // truncation toward zero: divide magnitudes, then restore the sign
    assign quo_low  = div_quo[SAMPLE_BITS-1:0];
    assign mean_val = r_sum[SUM_BITS-1] ? (~quo_low + 1'b1) : quo_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= LENGTH_BITS'(1);
            r_size <= LENGTH_BITS'(1);
            r_mode <= MODE_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LENGTH: r_len  <= i_cfg_data;
                CFG_SIZE:   r_size <= i_cfg_data;
                CFG_MODE:   r_mode <= t_mode'(i_cfg_data[1:0]);
                default:    ;
            endcase
        end
    end

    always_comb begin
        n_seen    = r_seen;
        n_bins    = r_bins;
        n_bound   = r_bound;
        n_bin_end = r_bin_end;
        n_ext     = r_ext;
        n_sum     = r_sum;
        n_fill    = r_fill;
        if (i_cmd.clear || (i_cmd.emit && last)) begin
            n_seen  = '0;
            n_bins  = '0;
            n_bound = BOUND_BITS'(len_eff);
            n_ext   = '0;
            n_sum   = '0;
            n_fill  = '0;
        end else if (i_cmd.emit) begin
            n_bins  = r_bins + 1'b1;
            n_bound = r_bound + BOUND_BITS'(len_eff);
            n_fill  = '0;
        end else if (i_cmd.accept) begin
            n_seen = r_seen + 1'b1;
            n_fill = r_fill + 1'b1;
            if (r_fill == '0) begin
                n_ext = i_sample;
                n_sum = SUM_BITS'(i_sample);
            end else begin
                case (r_mode)
                    MODE_MAX:  if (i_sample > r_ext) n_ext = i_sample;
                    MODE_MIN:  if (i_sample < r_ext) n_ext = i_sample;
                    MODE_MAG:  if (x_mag > ext_mag) n_ext = i_sample;
                    default:   n_sum = r_sum + SUM_BITS'(i_sample);
                endcase
            end
        end
        if (i_cmd.load_end) begin
            n_bin_end = div_quo[LENGTH_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= '0;
            r_bins    <= '0;
            r_bound   <= '0;
            r_bin_end <= LENGTH_BITS'(1);
            r_fill    <= '0;
        end else begin
            r_seen    <= n_seen;
            r_bins    <= n_bins;
            r_bound   <= n_bound;
            r_bin_end <= n_bin_end;
            r_fill    <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ext <= n_ext;
        r_sum <= n_sum;
    end

    // divider operands: next bin boundary or bin mean
    always_comb begin
        div_start    = i_cmd.start_end_div || i_cmd.start_mean_div;
        div_dividend = DIV_BITS'({r_bound, 1'b0} + NUM_BITS'(bins_eff));
        div_divisor  = {bins_eff, 1'b0};
        if (i_cmd.start_mean_div) begin
            div_dividend = DIV_BITS'(sum_mag);
            div_divisor  = {1'b0, r_fill};
        end
    end

    bdec_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_value  <= (r_mode == MODE_MEAN) ? mean_val : r_ext;
            r_out_number <= r_bins;
            r_out_last   <= last;
        end
    end

    always_comb begin
        o_status.cfg_hit   = i_cfg_we && (i_cfg_idx == CFG_LENGTH || i_cfg_idx == CFG_SIZE
                                          || i_cfg_idx == CFG_MODE);
        o_status.at_end    = (({1'b0, r_seen} + 1'b1) >= {1'b0, r_bin_end});
        o_status.div_done  = !div_busy;
        o_status.out_free  = !r_out_valid || !i_stall;
        o_status.mean_mode = (r_mode == MODE_MEAN);
    end

    assign o_valid      = r_out_valid;
    assign o_bin_value  = r_out_value;
    assign o_bin_number = r_out_number;
    assign o_last_bin   = r_out_last;

endmodule

FILE: hdl/bdec_ctrl.sv
// controller state machine: sequences restart, boundary and mean divisions,
// sample intake and result emission; depends on bdec_pkg
`timescale 1ns / 1ps

module bdec_ctrl
    import bdec_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_status i_status,
    output logic    o_stall,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = (r_state != ST_RUN);
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state     = ST_INIT;
            end
            ST_INIT: begin
                o_cmd.start_end_div = 1'b1;
                n_state             = ST_END_DIV;
            end
            ST_END_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.load_end = 1'b1;
                    n_state        = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.at_end) begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (i_status.mean_mode) begin
                    o_cmd.start_mean_div = 1'b1;
                    n_state              = ST_MEAN_DIV;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_MEAN_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_INIT;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
        // a register write drops the vector in progress
        if (i_status.cfg_hit) begin
            n_state = ST_CLEAR;
        end
    end

endmodule

FILE: hdl/bdec_chk.sv
// port-level checker for the binned decimator, bound to the top level
// depends on bdec_pkg
`timescale 1ns / 1ps

module bdec_chk
    import bdec_pkg::*;
(
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_we,
    input logic [CFG_IDX_BITS-1:0]       i_cfg_idx,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic signed [SAMPLE_BITS-1:0] o_bin_value,
    input logic [LENGTH_BITS-1:0]        o_bin_number,
    input logic                          o_last_bin
);

    // reset leaves no result and no open intake
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_stall && !o_valid))
        else $error("output valid or input open after reset");

    // a register write always restarts and closes the intake
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_idx == CFG_LENGTH || i_cfg_idx == CFG_SIZE
                      || i_cfg_idx == CFG_MODE)) |=> o_stall)
        else $error("input open right after a register write");

    // a new result is loaded only while the next boundary is being computed
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> o_stall)
        else $error("result appeared while input open");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_bin_value)
                                  && $stable(o_bin_number) && $stable(o_last_bin)))
        else $error("stalled result changed");

endmodule

bind binned_decimator_int bdec_chk u_chk (.*);
